### sv/tsa_pkg.sv
// tsa_pkg: shared types, widths and codes for the throttle source arbiter
// depends on nothing; imported by every module of the block
package tsa_pkg;

    localparam int THROTTLE_BITS     = 16;
    localparam int TIME_BITS_DEFAULT = 32;
    localparam int TICK_BITS         = 16;
    localparam int CFG_DATA_BITS     = 24;
    localparam int LIMIT_BITS        = 24;
    localparam int SLEW_BITS         = 24;
    localparam int SLEW_FRAC_BITS    = 16;
    localparam int STEP_BITS         = SLEW_BITS + TICK_BITS - SLEW_FRAC_BITS;
    localparam int CMP_BITS          =
        ((THROTTLE_BITS > STEP_BITS) ? THROTTLE_BITS : STEP_BITS) + 1;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int SEQ_BITS          = 32;
    localparam int FLAG_BITS         = 4;

    // status flag bit positions
    localparam int FLAG_SLEWING       = 0;
    localparam int FLAG_NO_SOURCE     = 1;
    localparam int FLAG_PULSE_ACTIVE  = 2;
    localparam int FLAG_PULSE_LOCKOUT = 3;

    // register defaults
    localparam logic [CFG_DATA_BITS-1:0] BUS_STALE_DEFAULT   = 24'd100000;
    localparam logic [CFG_DATA_BITS-1:0] PULSE_STALE_DEFAULT = 24'd100000;
    localparam logic [THROTTLE_BITS-1:0] ARM_LOW_THR_DEFAULT = 16'd1311;
    localparam logic [CFG_DATA_BITS-1:0] ARM_LOW_TIME_DEFAULT = 24'd500000;
    localparam logic [THROTTLE_BITS-1:0] TRACK_TOL_DEFAULT   = 16'd3277;
    localparam logic [CFG_DATA_BITS-1:0] TRACK_TIME_DEFAULT  = 24'd1000000;
    localparam logic [SLEW_BITS-1:0]     SLEW_DEFAULT        = 24'd65536;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_BUS   = 2'd1,
        SRC_PULSE = 2'd2
    } src_t;

    typedef enum logic [1:0] {
        POL_BUS_PRIMARY     = 2'd0,
        POL_BUS_ONLY        = 2'd1,
        POL_PULSE_ONLY      = 2'd2,
        POL_BUS_PRIMARY_ALT = 2'd3
    } policy_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_POLICY       = 3'd0,
        CFG_BUS_STALE    = 3'd1,
        CFG_PULSE_STALE  = 3'd2,
        CFG_ARM_LOW_THR  = 3'd3,
        CFG_ARM_LOW_TIME = 3'd4,
        CFG_TRACK_TOL    = 3'd5,
        CFG_TRACK_TIME   = 3'd6,
        CFG_HANDOFF_SLEW = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic                     bus_fresh;
        logic                     bus_valid;
        logic [THROTTLE_BITS-1:0] bus_throttle;
        logic                     bus_arm_request;
        logic                     pulse_fresh;
        logic                     pulse_valid;
        logic [THROTTLE_BITS-1:0] pulse_throttle;
        logic [TICK_BITS-1:0]     tick_time;
    } tsa_in_t;

    typedef struct packed {
        logic                     have_command;
        logic [1:0]               active_source;
        logic [THROTTLE_BITS-1:0] throttle_cmd;
        logic                     out_arm;
        logic [SEQ_BITS-1:0]      sequence_res;
        logic [FLAG_BITS-1:0]     status_flags;
    } tsa_out_t;

    // per-source health after this item's update
    typedef struct packed {
        logic                     ok;
        logic [THROTTLE_BITS-1:0] thr;
        logic                     arm;
    } tsa_health_t;

    // pulse qualification after this item's update
    typedef struct packed {
        logic armed;
        logic track_good;
    } tsa_qual_t;

endpackage

### sv/tsa_in_reg.sv
// tsa_in_reg: input register of the arbiter, also forms the slew step product
// depends on tsa_pkg
module tsa_in_reg
    import tsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tsa_in_t              s_data,
    input  logic [SLEW_BITS-1:0] handoff_slew,
    input  logic                 advance,
    output logic                 item_valid,
    output tsa_in_t              item,
    output logic [STEP_BITS-1:0] step
);

    logic                           valid_reg;
    logic                           valid_next;
    tsa_in_t                        item_reg;
    logic [STEP_BITS-1:0]           step_reg;
    logic [SLEW_BITS+TICK_BITS-1:0] product;

    assign s_ready = !valid_reg || advance;
    assign product = (SLEW_BITS+TICK_BITS)'(handoff_slew)
                   * (SLEW_BITS+TICK_BITS)'(s_data.tick_time);

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_data;
            step_reg <= product[SLEW_BITS+TICK_BITS-1:SLEW_FRAC_BITS];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign step       = step_reg;

endmodule

### sv/tsa_health.sv
// tsa_health: ageing and held sample of one throttle source
// depends on tsa_pkg
module tsa_health
    import tsa_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic                     frame_new,
    input  logic [THROTTLE_BITS-1:0] thr,
    input  logic                     arm,
    input  logic [TICK_BITS-1:0]     dt,
    input  logic [LIMIT_BITS-1:0]    stale_limit,
    output tsa_health_t              health
);

    logic                     seen_reg, seen_next;
    logic [TIME_BITS-1:0]     age_reg, age_next;
    logic [THROTTLE_BITS-1:0] thr_reg, thr_next;
    logic                     arm_reg, arm_next;
    logic [TIME_BITS:0]       age_sum;
    logic [TIME_BITS-1:0]     age_inc;
    logic                     ok;

    // saturating age
    assign age_sum = {1'b0, age_reg} + (TIME_BITS+1)'(dt);
    assign age_inc = age_sum[TIME_BITS] ? '1 : age_sum[TIME_BITS-1:0];

    always_comb begin
        if (frame_new) begin
            seen_next = 1'b1;
            age_next  = '0;
            thr_next  = thr;
            arm_next  = arm;
        end else begin
            seen_next = seen_reg;
            age_next  = age_inc;
            thr_next  = thr_reg;
            arm_next  = arm_reg;
        end
        ok = seen_next && (age_next <= TIME_BITS'(stale_limit));
        // unhealthy source holds nothing
        if (!ok) begin
            thr_next = '0;
            arm_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
            age_reg  <= '0;
            thr_reg  <= '0;
            arm_reg  <= 1'b0;
        end else if (advance) begin
            seen_reg <= seen_next;
            age_reg  <= age_next;
            thr_reg  <= thr_next;
            arm_reg  <= arm_next;
        end
    end

    assign health = '{ok: ok, thr: thr_next, arm: arm_next};

endmodule

### sv/tsa_pulse_qual.sv
// tsa_pulse_qual: arming dwell of the pulse source and its tracking of the bus
// depends on tsa_pkg
module tsa_pulse_qual
    import tsa_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic [TICK_BITS-1:0]     dt,
    input  tsa_health_t              bus_h,
    input  tsa_health_t              pulse_h,
    input  logic [THROTTLE_BITS-1:0] arm_low_threshold,
    input  logic [LIMIT_BITS-1:0]    arm_low_time,
    input  logic [THROTTLE_BITS-1:0] track_tolerance,
    input  logic [LIMIT_BITS-1:0]    track_time,
    output tsa_qual_t                qual
);

    logic [TIME_BITS-1:0]     low_dwell_reg, low_dwell_next;
    logic                     armed_reg, armed_next;
    logic [TIME_BITS-1:0]     track_dwell_reg, track_dwell_next;
    logic                     track_good_reg, track_good_next;
    logic [TIME_BITS:0]       low_sum, track_sum;
    logic [TIME_BITS-1:0]     low_inc, track_inc;
    logic [THROTTLE_BITS-1:0] diff;

    assign low_sum   = {1'b0, low_dwell_reg} + (TIME_BITS+1)'(dt);
    assign low_inc   = low_sum[TIME_BITS] ? '1 : low_sum[TIME_BITS-1:0];
    assign track_sum = {1'b0, track_dwell_reg} + (TIME_BITS+1)'(dt);
    assign track_inc = track_sum[TIME_BITS] ? '1 : track_sum[TIME_BITS-1:0];
    assign diff      = (pulse_h.thr >= bus_h.thr) ? (pulse_h.thr - bus_h.thr)
                                                  : (bus_h.thr - pulse_h.thr);

    // arming dwell: armed with high throttle keeps the dwell
    always_comb begin
        low_dwell_next = low_dwell_reg;
        armed_next     = armed_reg;
        if (!pulse_h.ok) begin
            low_dwell_next = '0;
            armed_next     = 1'b0;
        end else if (pulse_h.thr <= arm_low_threshold) begin
            low_dwell_next = low_inc;
            armed_next     = armed_reg || (low_inc >= TIME_BITS'(arm_low_time));
        end else if (!armed_reg) begin
            low_dwell_next = '0;
        end
    end

    // tracking dwell: holds while the bus is unhealthy
    always_comb begin
        track_dwell_next = track_dwell_reg;
        track_good_next  = track_good_reg;
        if (!pulse_h.ok) begin
            track_dwell_next = '0;
            track_good_next  = 1'b0;
        end else if (bus_h.ok) begin
            if (diff <= track_tolerance) begin
                track_dwell_next = track_inc;
                track_good_next  = track_good_reg
                                || (track_inc >= TIME_BITS'(track_time));
            end else begin
                track_dwell_next = '0;
                track_good_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_dwell_reg   <= '0;
            armed_reg       <= 1'b0;
            track_dwell_reg <= '0;
            track_good_reg  <= 1'b0;
        end else if (advance) begin
            low_dwell_reg   <= low_dwell_next;
            armed_reg       <= armed_next;
            track_dwell_reg <= track_dwell_next;
            track_good_reg  <= track_good_next;
        end
    end

    assign qual = '{armed: armed_next, track_good: track_good_next};

endmodule

### sv/throttle_source_arbiter_core.sv
// throttle_source_arbiter_core: top level of the throttle source arbiter
// depends on tsa_pkg, tsa_in_reg, tsa_health and tsa_pulse_qual
//
// One item per control tick carries a bus sample, a pulse sample and the time
// since the previous tick. Each item yields exactly one result item, in order.
// An item is held in the input register (where the handoff slew step,
// slew rate times tick time, is multiplied out), then one pass of logic ages
// both sources, qualifies the pulse source, picks a source by policy and slews
// the output into the result register, which is loaded once it is free or
// being emptied; m_valid rises with it. A new item is taken in every cycle
// while the result side keeps up; s_ready only drops while both registers
// are full and m_ready is low. The longest path runs age update, health,
// tracking dwell, source choice and slew compare. The user must write the
// registers through cfg_we, cfg_addr and cfg_wdata only while no item is in
// flight; the block itself does not enforce this. TIME_BITS sets the width
// of the saturating ages and dwells.
module throttle_source_arbiter_core
    import tsa_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input items
    input  logic                      s_valid,
    output logic                      s_ready,
    input  tsa_in_t                   s_data,
    // result items
    output logic                      m_valid,
    input  logic                      m_ready,
    output tsa_out_t                  m_data,
    // register writes
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    // configuration registers
    policy_t                  policy_reg;
    logic [LIMIT_BITS-1:0]    bus_stale_reg;
    logic [LIMIT_BITS-1:0]    pulse_stale_reg;
    logic [THROTTLE_BITS-1:0] arm_low_thr_reg;
    logic [LIMIT_BITS-1:0]    arm_low_time_reg;
    logic [THROTTLE_BITS-1:0] track_tol_reg;
    logic [LIMIT_BITS-1:0]    track_time_reg;
    logic [SLEW_BITS-1:0]     slew_reg;

    // input stage
    logic                     item_valid;
    tsa_in_t                  item;
    logic [STEP_BITS-1:0]     step;
    logic                     advance;

    // per-item results of the sub-blocks
    tsa_health_t              bus_h;
    tsa_health_t              pulse_h;
    tsa_qual_t                qual;

    // selection and output state
    src_t                     cur_src_reg, cand;
    logic                     blending_reg, blending_next;
    logic [THROTTLE_BITS-1:0] level_reg, level_next;
    logic [SEQ_BITS-1:0]      seq_reg, seq_next;
    logic [THROTTLE_BITS-1:0] target;
    logic                     sel_arm;
    logic                     sel_fresh;
    logic                     primary;
    logic [FLAG_BITS-1:0]     flags;
    logic [CMP_BITS-1:0]      target_ext, level_ext, step_ext;
    logic                     m_valid_reg, m_valid_next;
    tsa_out_t                 m_data_reg, m_data_next;

    // an item waiting and the result register free, or being emptied this cycle
    assign advance = item_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg       <= POL_BUS_PRIMARY;
            bus_stale_reg    <= BUS_STALE_DEFAULT;
            pulse_stale_reg  <= PULSE_STALE_DEFAULT;
            arm_low_thr_reg  <= ARM_LOW_THR_DEFAULT;
            arm_low_time_reg <= ARM_LOW_TIME_DEFAULT;
            track_tol_reg    <= TRACK_TOL_DEFAULT;
            track_time_reg   <= TRACK_TIME_DEFAULT;
            slew_reg         <= SLEW_DEFAULT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_POLICY:       policy_reg       <= policy_t'(cfg_wdata[1:0]);
                CFG_BUS_STALE:    bus_stale_reg    <= cfg_wdata[LIMIT_BITS-1:0];
                CFG_PULSE_STALE:  pulse_stale_reg  <= cfg_wdata[LIMIT_BITS-1:0];
                CFG_ARM_LOW_THR:  arm_low_thr_reg  <= cfg_wdata[THROTTLE_BITS-1:0];
                CFG_ARM_LOW_TIME: arm_low_time_reg <= cfg_wdata[LIMIT_BITS-1:0];
                CFG_TRACK_TOL:    track_tol_reg    <= cfg_wdata[THROTTLE_BITS-1:0];
                CFG_TRACK_TIME:   track_time_reg   <= cfg_wdata[LIMIT_BITS-1:0];
                CFG_HANDOFF_SLEW: slew_reg         <= cfg_wdata[SLEW_BITS-1:0];
                default: ;
            endcase
        end
    end

    tsa_in_reg u_in_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .handoff_slew (slew_reg),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item),
        .step         (step)
    );

    tsa_health #(.TIME_BITS(TIME_BITS)) u_bus_health (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .frame_new   (item.bus_fresh && item.bus_valid),
        .thr         (item.bus_throttle),
        .arm         (item.bus_arm_request),
        .dt          (item.tick_time),
        .stale_limit (bus_stale_reg),
        .health      (bus_h)
    );

    // the pulse source carries no arm request of its own
    tsa_health #(.TIME_BITS(TIME_BITS)) u_pulse_health (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .frame_new   (item.pulse_fresh && item.pulse_valid),
        .thr         (item.pulse_throttle),
        .arm         (1'b0),
        .dt          (item.tick_time),
        .stale_limit (pulse_stale_reg),
        .health      (pulse_h)
    );

    tsa_pulse_qual #(.TIME_BITS(TIME_BITS)) u_pulse_qual (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .advance           (advance),
        .dt                (item.tick_time),
        .bus_h             (bus_h),
        .pulse_h           (pulse_h),
        .arm_low_threshold (arm_low_thr_reg),
        .arm_low_time      (arm_low_time_reg),
        .track_tolerance   (track_tol_reg),
        .track_time        (track_time_reg),
        .qual              (qual)
    );

    // source choice by policy
    always_comb begin
        primary = (policy_reg == POL_BUS_PRIMARY) || (policy_reg == POL_BUS_PRIMARY_ALT);
        cand    = SRC_NONE;
        case (policy_reg)
            POL_BUS_ONLY: begin
                if (bus_h.ok) cand = SRC_BUS;
            end
            POL_PULSE_ONLY: begin
                if (pulse_h.ok && qual.armed) cand = SRC_PULSE;
            end
            default: begin
                // bus first, pulse only once armed and proven to track
                if (bus_h.ok) begin
                    cand = SRC_BUS;
                end else if (pulse_h.ok && qual.armed && qual.track_good) begin
                    cand = SRC_PULSE;
                end
            end
        endcase
    end

    always_comb begin
        target    = '0;
        sel_arm   = 1'b0;
        sel_fresh = 1'b0;
        if (cand == SRC_BUS) begin
            target    = bus_h.thr;
            sel_arm   = bus_h.arm;
            sel_fresh = item.bus_fresh && item.bus_valid;
        end else if (cand == SRC_PULSE) begin
            target    = pulse_h.thr;
            sel_arm   = qual.armed;
            sel_fresh = item.pulse_fresh && item.pulse_valid;
        end
    end

    assign target_ext = CMP_BITS'(target);
    assign level_ext  = CMP_BITS'(level_reg);
    assign step_ext   = CMP_BITS'(step);

    // output level with handoff slew
    always_comb begin
        flags         = '0;
        blending_next = blending_reg;
        level_next    = level_reg;
        // a change between two real sources starts a slewed handoff
        if (cand != cur_src_reg && cand != SRC_NONE && cur_src_reg != SRC_NONE) begin
            blending_next = 1'b1;
        end
        if (cand == SRC_NONE) begin
            level_next    = '0;
            blending_next = 1'b0;
        end else if (blending_next) begin
            if (target_ext > level_ext + step_ext) begin
                level_next = THROTTLE_BITS'(level_ext + step_ext);
            end else if (target_ext + step_ext < level_ext) begin
                level_next = THROTTLE_BITS'(level_ext - step_ext);
            end else begin
                // within one step: land on the target
                level_next    = target;
                blending_next = 1'b0;
            end
            flags[FLAG_SLEWING] = 1'b1;
        end else begin
            level_next = target;
        end

        seq_next = seq_reg;
        if (cand != SRC_NONE && sel_fresh) begin
            seq_next = seq_reg + 1'b1;
        end

        if (cand == SRC_NONE) begin
            flags[FLAG_NO_SOURCE] = 1'b1;
        end else if (cand == SRC_PULSE) begin
            flags[FLAG_PULSE_ACTIVE] = 1'b1;
        end
        // pulse ready to fly but not yet trusted to follow the bus
        if (primary && pulse_h.ok && qual.armed && !qual.track_good) begin
            flags[FLAG_PULSE_LOCKOUT] = 1'b1;
        end
    end

    always_comb begin
        m_data_next.have_command  = (cand != SRC_NONE);
        m_data_next.active_source = cand;
        m_data_next.throttle_cmd  = (cand != SRC_NONE) ? level_next : '0;
        m_data_next.out_arm       = (cand != SRC_NONE) && sel_arm;
        m_data_next.sequence_res  = seq_next;
        m_data_next.status_flags  = flags;

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_src_reg  <= SRC_NONE;
            blending_reg <= 1'b0;
            level_reg    <= '0;
            seq_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                cur_src_reg  <= cand;
                blending_reg <= blending_next;
                level_reg    <= level_next;
                seq_reg      <= seq_next;
            end
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // the no-source flag always mirrors the command indication
    a_no_source_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.status_flags[FLAG_NO_SOURCE] == !m_data_reg.have_command))
        else $error("no-source flag disagrees with have_command");

    // without a source the command is zeroed and never slewing
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.have_command) |->
            (m_data_reg.throttle_cmd == '0 && !m_data_reg.out_arm
             && !m_data_reg.status_flags[FLAG_SLEWING]))
        else $error("command not zeroed without a source");

    // the sequence moves by at most one per item
    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (seq_reg == $past(seq_reg) || seq_reg == $past(seq_reg) + 1'b1))
        else $error("sequence jumped by more than one");

    // a stalled item stays in the input register
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && !advance) |=> item_valid)
        else $error("input item lost while stalled");

    // blending needs a source
    a_blend_src: assert property (@(posedge aclk) disable iff (!aresetn)
        blending_reg |-> (cur_src_reg != SRC_NONE))
        else $error("handoff slew active without a source");

endmodule

### verif/tb_throttle_source_arbiter_core.sv
// tb_throttle_source_arbiter_core: self-checking testbench for the throttle source arbiter
// depends on tsa_pkg and throttle_source_arbiter_core; a scoreboard class predicts each
// command item from the tick items the block accepts
module tb_throttle_source_arbiter_core;
    import tsa_pkg::*;

    localparam int AGE_BITS = TIME_BITS_DEFAULT;

    // scoreboard: shadow registers, shadow arbiter state and the queue of predicted commands
    class command_scoreboard;
        policy_t                  pol;
        logic [LIMIT_BITS-1:0]    bus_limit, pulse_limit, low_time, trk_time;
        logic [SLEW_BITS-1:0]     slew;
        logic [THROTTLE_BITS-1:0] low_thr, trk_tol;
        logic                     b_seen, b_arm, p_seen, p_armed, trk_ok, slewing;
        logic [AGE_BITS-1:0]      b_age, p_age, low_acc, trk_acc;
        logic [THROTTLE_BITS-1:0] b_thr, p_thr, level;
        logic [SEQ_BITS-1:0]      seq;
        src_t                     src;
        tsa_out_t                 expected_cmds[$];
        int                       errors;

        function new();
            pol         = POL_BUS_PRIMARY;
            bus_limit   = BUS_STALE_DEFAULT;
            pulse_limit = PULSE_STALE_DEFAULT;
            low_thr     = ARM_LOW_THR_DEFAULT;
            low_time    = ARM_LOW_TIME_DEFAULT;
            trk_tol     = TRACK_TOL_DEFAULT;
            trk_time    = TRACK_TIME_DEFAULT;
            slew        = SLEW_DEFAULT;
            {b_seen, b_arm, p_seen, p_armed, trk_ok, slewing} = '0;
            {b_age, p_age, low_acc, trk_acc} = '0;
            {b_thr, p_thr, level, seq} = '0;
            src    = SRC_NONE;
            errors = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] v);
            case (idx)
                CFG_POLICY:       pol = policy_t'(v[1:0]);
                CFG_BUS_STALE:    bus_limit = v;
                CFG_PULSE_STALE:  pulse_limit = v;
                CFG_ARM_LOW_THR:  low_thr = v[THROTTLE_BITS-1:0];
                CFG_ARM_LOW_TIME: low_time = v;
                CFG_TRACK_TOL:    trk_tol = v[THROTTLE_BITS-1:0];
                CFG_TRACK_TIME:   trk_time = v;
                default:          slew = v;
            endcase
        endfunction

        function logic [AGE_BITS-1:0] sat_add(logic [AGE_BITS-1:0] a, logic [TICK_BITS-1:0] d);
            logic [AGE_BITS:0] s;
            s = {1'b0, a} + (AGE_BITS+1)'(d);
            return s[AGE_BITS] ? '1 : s[AGE_BITS-1:0];
        endfunction

        // advance the shadow arbiter by one tick and return the command it gives
        function tsa_out_t next_command(tsa_in_t t);
            logic                     b_new, p_new, b_ok, p_ok, arm, fresh;
            logic [THROTTLE_BITS-1:0] diff, target;
            logic [39:0]              prod;
            logic [31:0]              step;
            src_t                     pick;
            tsa_out_t                 r;
            b_new = t.bus_fresh & t.bus_valid;
            p_new = t.pulse_fresh & t.pulse_valid;

            // source ageing
            if (b_new) begin
                b_seen = 1'b1;
                b_age  = '0;
                b_thr  = t.bus_throttle;
                b_arm  = t.bus_arm_request;
            end else begin
                b_age = sat_add(b_age, t.tick_time);
            end
            b_ok = b_seen && (b_age <= bus_limit);
            if (!b_ok) begin
                b_thr = '0;
                b_arm = 1'b0;
            end
            if (p_new) begin
                p_seen = 1'b1;
                p_age  = '0;
                p_thr  = t.pulse_throttle;
            end else begin
                p_age = sat_add(p_age, t.tick_time);
            end
            p_ok = p_seen && (p_age <= pulse_limit);
            if (!p_ok)
                p_thr = '0;

            // arming dwell; an armed pulse source with high throttle keeps its dwell
            if (!p_ok) begin
                low_acc = '0;
                p_armed = 1'b0;
            end else if (p_thr <= low_thr) begin
                low_acc = sat_add(low_acc, t.tick_time);
                if (low_acc >= low_time)
                    p_armed = 1'b1;
            end else if (!p_armed) begin
                low_acc = '0;
            end

            // tracking dwell holds while the bus source is unhealthy
            if (!p_ok) begin
                trk_acc = '0;
                trk_ok  = 1'b0;
            end else if (b_ok) begin
                diff = (p_thr >= b_thr) ? p_thr - b_thr : b_thr - p_thr;
                if (diff <= trk_tol) begin
                    trk_acc = sat_add(trk_acc, t.tick_time);
                    if (trk_acc >= trk_time)
                        trk_ok = 1'b1;
                end else begin
                    trk_acc = '0;
                    trk_ok  = 1'b0;
                end
            end

            pick = SRC_NONE;
            case (pol)
                POL_BUS_ONLY: begin
                    if (b_ok)
                        pick = SRC_BUS;
                end
                POL_PULSE_ONLY: begin
                    if (p_ok && p_armed)
                        pick = SRC_PULSE;
                end
                default: begin
                    if (b_ok)
                        pick = SRC_BUS;
                    else if (p_ok && p_armed && trk_ok)
                        pick = SRC_PULSE;
                end
            endcase
            target = '0;
            arm    = 1'b0;
            fresh  = 1'b0;
            if (pick == SRC_BUS) begin
                target = b_thr;
                arm    = b_arm;
                fresh  = b_new;
            end else if (pick == SRC_PULSE) begin
                target = p_thr;
                arm    = p_armed;
                fresh  = p_new;
            end

            // handoff slew between two real sources
            r = '0;
            if (pick != src && pick != SRC_NONE && src != SRC_NONE)
                slewing = 1'b1;
            if (pick == SRC_NONE) begin
                level   = '0;
                slewing = 1'b0;
            end else if (slewing) begin
                prod = 40'(slew) * 40'(t.tick_time);
                step = 32'(prod >> SLEW_FRAC_BITS);
                if (32'(target) > 32'(level) + step)
                    level = level + step[THROTTLE_BITS-1:0];
                else if (32'(target) + step < 32'(level))
                    level = level - step[THROTTLE_BITS-1:0];
                else begin
                    level   = target;
                    slewing = 1'b0;
                end
                r.status_flags[FLAG_SLEWING] = 1'b1;
            end else begin
                level = target;
            end
            src = pick;
            if (pick != SRC_NONE && fresh)
                seq = seq + 1'b1;

            r.have_command  = (pick != SRC_NONE);
            r.active_source = pick;
            r.throttle_cmd  = (pick != SRC_NONE) ? level : '0;
            r.out_arm       = (pick != SRC_NONE) && arm;
            r.sequence_res  = seq;
            r.status_flags[FLAG_NO_SOURCE]     = (pick == SRC_NONE);
            r.status_flags[FLAG_PULSE_ACTIVE]  = (pick == SRC_PULSE);
            r.status_flags[FLAG_PULSE_LOCKOUT] =
                (pol == POL_BUS_PRIMARY || pol == POL_BUS_PRIMARY_ALT) && p_ok && p_armed && !trk_ok;
            return r;
        endfunction

        function void note_tick(tsa_in_t t);
            expected_cmds.push_back(next_command(t));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_command(tsa_out_t got);
            tsa_out_t want;
            if (expected_cmds.size() == 0) begin
                $error("command item with no tick waiting for it");
                errors++;
                return;
            end
            want = expected_cmds.pop_front();
            compare_field("have_command", 32'(want.have_command), 32'(got.have_command));
            compare_field("active_source", 32'(want.active_source), 32'(got.active_source));
            compare_field("throttle_cmd", 32'(want.throttle_cmd), 32'(got.throttle_cmd));
            compare_field("out_arm", 32'(want.out_arm), 32'(got.out_arm));
            compare_field("sequence_res", want.sequence_res, got.sequence_res);
            compare_field("status_flags", 32'(want.status_flags), 32'(got.status_flags));
        endfunction

        function int outstanding();
            return expected_cmds.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    tsa_in_t                   s_data;
    logic                      m_valid;
    logic                      m_ready;
    tsa_out_t                  m_data;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    command_scoreboard sb = new();

    // idling knobs, in percent, plus a receiver hold-off counted down by the receiver itself
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_left     = 0;

    // random tick generator state: a common stick level that both sources follow,
    // and dropout counters during which a source delivers no valid frame
    logic [THROTTLE_BITS-1:0] level_base = '0;
    int bus_gap   = 0;
    int pulse_gap = 0;

    throttle_source_arbiter_core #(
        .TIME_BITS(AGE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // generous upper bound on the whole run
    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    // both handshakes are observed at the rising edge, before the block updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_tick(s_data);
            if (m_valid && m_ready)
                sb.check_command(m_data);
        end
    end

    // receiver: random stalls, or a long hold-off while hold_left runs down
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    // offer one tick, with random idle cycles ahead of it, and hold it until taken
    task automatic send_tick(input tsa_in_t t);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = t;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // stop offering and let every predicted command come out, plus a few spare cycles
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] v);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.set_reg(idx, v);
    endtask

    // limits and dwells scaled so that arming, tracking and handoffs happen within a phase
    task automatic load_moderate(input policy_t p);
        write_reg(CFG_POLICY, CFG_DATA_BITS'(p));
        write_reg(CFG_BUS_STALE, CFG_DATA_BITS'($urandom_range(2000, 20000)));
        write_reg(CFG_PULSE_STALE, CFG_DATA_BITS'($urandom_range(2000, 20000)));
        write_reg(CFG_ARM_LOW_THR, CFG_DATA_BITS'($urandom_range(500, 20000)));
        write_reg(CFG_ARM_LOW_TIME, CFG_DATA_BITS'($urandom_range(1000, 8000)));
        write_reg(CFG_TRACK_TOL, CFG_DATA_BITS'($urandom_range(1000, 8000)));
        write_reg(CFG_TRACK_TIME, CFG_DATA_BITS'($urandom_range(1000, 10000)));
        write_reg(CFG_HANDOFF_SLEW, CFG_DATA_BITS'($urandom_range(0, 200000)));
    endtask

    function automatic tsa_in_t mk_tick(logic bf, logic bv, logic [THROTTLE_BITS-1:0] bt,
                                        logic ba, logic pf, logic pv,
                                        logic [THROTTLE_BITS-1:0] pt, logic [TICK_BITS-1:0] dt);
        tsa_in_t t;
        t.bus_fresh       = bf;
        t.bus_valid       = bv;
        t.bus_throttle    = bt;
        t.bus_arm_request = ba;
        t.pulse_fresh     = pf;
        t.pulse_valid     = pv;
        t.pulse_throttle  = pt;
        t.tick_time       = dt;
        return t;
    endfunction

    function automatic logic [THROTTLE_BITS-1:0] wobble(logic [THROTTLE_BITS-1:0] centre,
                                                        int spread);
        int v;
        v = int'(centre) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        else if (v > 65535)
            v = 65535;
        return THROTTLE_BITS'(v);
    endfunction

    // mostly well-formed ticks around a shared stick level, with dropouts and some noise
    function automatic tsa_in_t next_tick();
        tsa_in_t     t;
        logic [63:0] raw;
        int          spread, r;
        raw = {$urandom, $urandom};
        t   = raw[$bits(tsa_in_t)-1:0];
        if ($urandom_range(0, 99) < 6)
            return t;
        r = $urandom_range(0, 99);
        if (r < 5)
            level_base = THROTTLE_BITS'($urandom_range(0, sb.low_thr));
        else if (r < 9)
            level_base = THROTTLE_BITS'($urandom);
        spread = int'(sb.trk_tol) / 2 + 1;

        if (bus_gap > 0) begin
            bus_gap--;
            t.bus_fresh = 1'($urandom_range(0, 1));
            t.bus_valid = 1'b0;
        end else begin
            if ($urandom_range(0, 99) < 3)
                bus_gap = $urandom_range(1, 40);
            t.bus_fresh = ($urandom_range(0, 99) < 90);
            t.bus_valid = ($urandom_range(0, 99) < 95);
        end
        t.bus_throttle    = wobble(level_base, spread);
        t.bus_arm_request = ($urandom_range(0, 99) < 80);

        if (pulse_gap > 0) begin
            pulse_gap--;
            t.pulse_fresh = 1'($urandom_range(0, 1));
            t.pulse_valid = 1'b0;
        end else begin
            if ($urandom_range(0, 99) < 3)
                pulse_gap = $urandom_range(1, 40);
            t.pulse_fresh = ($urandom_range(0, 99) < 90);
            t.pulse_valid = ($urandom_range(0, 99) < 95);
        end
        // now and then the pulse source strays far from the bus
        t.pulse_throttle = ($urandom_range(0, 99) < 12) ? THROTTLE_BITS'($urandom)
                                                        : wobble(level_base, spread);

        r = $urandom_range(0, 99);
        if (r < 8)
            t.tick_time = '0;
        else if (r < 65)
            t.tick_time = TICK_BITS'($urandom_range(1, 500));
        else if (r < 88)
            t.tick_time = TICK_BITS'($urandom_range(500, 5000));
        else if (r < 97)
            t.tick_time = TICK_BITS'($urandom_range(5000, 40000));
        else
            t.tick_time = '1;
        return t;
    endfunction

    initial begin
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_POLICY;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed ticks at the reset settings
        send_tick(mk_tick(0, 0, 16'h0000, 0, 0, 0, 16'h0000, 16'h0000));  // nothing seen yet
        send_tick(mk_tick(1, 0, 16'hFFFF, 1, 1, 0, 16'hFFFF, 16'h0000));  // fresh but invalid
        send_tick(mk_tick(1, 1, 16'hFFFF, 1, 0, 1, 16'h0000, 16'hFFFF));  // first bus frame
        // both sources close together with the pulse at the arming threshold:
        // arms after eight ticks, lockout until tracking is good after sixteen
        for (int i = 0; i < 16; i++)
            send_tick(mk_tick(1, 1, 16'd4000, i[0], 1, 1, ARM_LOW_THR_DEFAULT, 16'hFFFF));
        send_tick(mk_tick(0, 0, 16'h0000, 0, 1, 1, ARM_LOW_THR_DEFAULT, 16'hFFFF));
        // bus age lands exactly on the stale limit, then one microsecond past it
        send_tick(mk_tick(0, 0, 16'h0000, 0, 1, 1, ARM_LOW_THR_DEFAULT, 16'd34465));
        send_tick(mk_tick(0, 0, 16'h0000, 0, 1, 1, ARM_LOW_THR_DEFAULT, 16'd1));
        send_tick(mk_tick(0, 0, 16'h0000, 0, 1, 1, ARM_LOW_THR_DEFAULT, 16'd100));
        // bus returns mid-slew while the armed pulse goes high
        send_tick(mk_tick(1, 1, 16'hFFFF, 1, 1, 1, 16'hFFFF, 16'd10));
        send_tick(mk_tick(0, 0, 16'h0000, 0, 0, 1, 16'h0000, 16'd0));     // zero step
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                1: load_moderate(POL_BUS_PRIMARY);
                2: load_moderate(POL_BUS_ONLY);
                3: load_moderate(POL_PULSE_ONLY);
                4: begin
                    load_moderate(POL_BUS_PRIMARY_ALT);
                    write_reg(CFG_HANDOFF_SLEW, '0);
                end
                5: begin
                    // every register at its top value
                    write_reg(CFG_POLICY, CFG_DATA_BITS'(POL_BUS_PRIMARY_ALT));
                    write_reg(CFG_BUS_STALE, '1);
                    write_reg(CFG_PULSE_STALE, '1);
                    write_reg(CFG_ARM_LOW_THR, CFG_DATA_BITS'(16'hFFFF));
                    write_reg(CFG_ARM_LOW_TIME, '1);
                    write_reg(CFG_TRACK_TOL, CFG_DATA_BITS'(16'hFFFF));
                    write_reg(CFG_TRACK_TIME, '1);
                    write_reg(CFG_HANDOFF_SLEW, '1);
                end
                6: begin
                    // every register at zero
                    write_reg(CFG_POLICY, CFG_DATA_BITS'(POL_BUS_PRIMARY));
                    write_reg(CFG_BUS_STALE, '0);
                    write_reg(CFG_PULSE_STALE, '0);
                    write_reg(CFG_ARM_LOW_THR, '0);
                    write_reg(CFG_ARM_LOW_TIME, '0);
                    write_reg(CFG_TRACK_TOL, '0);
                    write_reg(CFG_TRACK_TIME, '0);
                    write_reg(CFG_HANDOFF_SLEW, '0);
                end
                7: begin
                    write_reg(CFG_POLICY, CFG_DATA_BITS'($urandom_range(0, 3)));
                    write_reg(CFG_BUS_STALE, CFG_DATA_BITS'($urandom));
                    write_reg(CFG_PULSE_STALE, CFG_DATA_BITS'($urandom));
                    write_reg(CFG_ARM_LOW_THR, CFG_DATA_BITS'(16'($urandom)));
                    write_reg(CFG_ARM_LOW_TIME, CFG_DATA_BITS'($urandom));
                    write_reg(CFG_TRACK_TOL, CFG_DATA_BITS'(16'($urandom)));
                    write_reg(CFG_TRACK_TIME, CFG_DATA_BITS'($urandom));
                    write_reg(CFG_HANDOFF_SLEW, CFG_DATA_BITS'($urandom));
                end
                8: begin
                    load_moderate(policy_t'($urandom_range(0, 3)));
                    write_reg(CFG_HANDOFF_SLEW, CFG_DATA_BITS'($urandom_range(1 << 20, 24'hFFFFFF)));
                end
                9: load_moderate(POL_BUS_PRIMARY);
                default: ;  // reset settings
            endcase

            case (ph % 4)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 76;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 76;
                end
                default: begin
                    src_idle_pct  = 19;
                    snk_stall_pct = 19;
                end
            endcase

            for (int n = 0; n < 125; n++) begin
                // sender pauses until every command is out
                if (ph == 1 && n == 60)
                    wait_idle();
                // long receiver hold-off with the sender pushing: fills the block up
                if (ph == 8 && n == 40) begin
                    src_idle_pct = 0;
                    hold_left    = 60;
                end
                send_tick(next_tick());
            end

            if (ph == 5) begin
                // longest ticks at the top settings: first with both sources fresh,
                // then with no frames at all so the ages climb
                src_idle_pct  = 0;
                snk_stall_pct = 0;
                for (int n = 0; n < 30; n++)
                    send_tick(mk_tick(1, 1, 16'h0000, n[0], 1, 1, 16'h0000, 16'hFFFF));
                for (int n = 0; n < 30; n++)
                    send_tick(mk_tick(0, n[0], 16'hFFFF, 1, n[1], 0, 16'hFFFF, 16'hFFFF));
            end
            wait_idle();
        end

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
sv/tsa_pkg.sv
sv/tsa_in_reg.sv
sv/tsa_health.sv
sv/tsa_pulse_qual.sv
sv/throttle_source_arbiter_core.sv
verif/tb_throttle_source_arbiter_core.sv
